>>> src/cfbp_pkg.sv
// Package for the capture frame boundary parser.
// Holds field widths, run-length decode constants and the run-length function.
// No dependencies.
package cfbp_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned WordW  = 32;
  localparam int unsigned SumW   = 40;
  localparam int unsigned CoordW = 3;

  localparam logic [ByteW-1:0]  RunExpBase   = 8'hE0;
  localparam logic [ByteW-1:0]  RunExpOffset = 8'd7;

  // Coordinate word positions within a rectangle header
  localparam logic [CoordW-1:0] CoordLeft   = 3'd1;
  localparam logic [CoordW-1:0] CoordTop    = 3'd2;
  localparam logic [CoordW-1:0] CoordRight  = 3'd3;
  localparam logic [CoordW-1:0] CoordBottom = 3'd4;

  localparam logic [1:0] PhaseLast = 2'd3;

  function automatic logic [SumW-1:0] run_length(input logic [ByteW-1:0] b);
    logic [ByteW-1:0] sh;
    logic [SumW-1:0]  len;
    sh = b - RunExpBase + RunExpOffset;
    if (b < RunExpBase) begin
      len = SumW'(b) + SumW'(1);
    end else begin
      len = SumW'(1) << sh[5:0];
    end
    return len;
  endfunction

endpackage

>>> src/capture_frame_boundary_parser.sv
// Capture frame boundary parser top level: word assembly, header and run parsing.
// Depends on cfbp_pkg.
//
// channel   dir  transfer content
// s_axis    in   tdata = data_byte
// m_axis    out  tdata = frame_pts, tlast = frame_end, tuser = key_flag
//
// One result per input byte, one byte per cycle unless stalled; outputs registered.
// Rectangle area is registered from the stored corners; a run word needs at
// least four bytes after the last corner word, so the area is always settled.
// Output register frees s_axis_tready whenever it is empty or being taken.
// Asynchronous active-low reset clears all parse state.
module capture_frame_boundary_parser (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [cfbp_pkg::ByteW-1:0]  s_axis_tdata,   // [7:0] data_byte
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [cfbp_pkg::WordW-1:0]  m_axis_tdata,   // [31:0] frame_pts
  output logic                        m_axis_tlast,   // frame_end
  output logic                        m_axis_tuser    // [0] key_flag
);
  import cfbp_pkg::*;

  logic [23:0]       shift_q, shift_d;
  logic [1:0]        phase_q, phase_d;
  logic              have_stamp_q, have_stamp_d;
  logic              have_count_q, have_count_d;
  logic              have_rect_q, have_rect_d;
  logic [CoordW-1:0] coord_q, coord_d;
  logic [WordW-1:0]  rect_total_q, rect_total_d;
  logic [WordW-1:0]  rect_done_q, rect_done_d;
  logic [WordW-1:0]  left_x_q, left_x_d;
  logic [WordW-1:0]  top_y_q, top_y_d;
  logic [WordW-1:0]  right_x_q, right_x_d;
  logic [WordW-1:0]  bottom_y_q, bottom_y_d;
  logic [WordW-1:0]  area_q;
  logic [SumW-1:0]   run_sum_q, run_sum_d;
  logic              seen_q, seen_d;
  logic [WordW-1:0]  stamp_q, stamp_d;

  logic              out_valid_q;
  logic              out_last_q, out_last_d;
  logic              out_key_q, out_key_d;
  logic [WordW-1:0]  out_pts_q, out_pts_d;

  logic              accept;
  logic [WordW-1:0]  word;
  logic [SumW-1:0]   sum_next;
  logic [WordW-1:0]  done_next;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign word      = {s_axis_tdata, shift_q[7:0], shift_q[15:8], shift_q[23:16]};
  assign sum_next  = run_sum_q + run_length(s_axis_tdata);
  assign done_next = rect_done_q + WordW'(1);

  always_comb begin
    shift_d      = {shift_q[15:0], s_axis_tdata};
    phase_d      = phase_q + 2'd1;
    have_stamp_d = have_stamp_q;
    have_count_d = have_count_q;
    have_rect_d  = have_rect_q;
    coord_d      = coord_q;
    rect_total_d = rect_total_q;
    rect_done_d  = rect_done_q;
    left_x_d     = left_x_q;
    top_y_d      = top_y_q;
    right_x_d    = right_x_q;
    bottom_y_d   = bottom_y_q;
    run_sum_d    = run_sum_q;
    seen_d       = seen_q;
    stamp_d      = stamp_q;
    out_last_d   = 1'b0;
    out_key_d    = 1'b0;
    out_pts_d    = '0;
    if (phase_q == PhaseLast) begin
      if (!have_stamp_q) begin
        have_stamp_d = 1'b1;
        stamp_d      = word;
        rect_done_d  = '0;
      end else if (!have_count_q) begin
        have_count_d = 1'b1;
        rect_total_d = word;
      end else if (!have_rect_q) begin
        coord_d = coord_q + CoordW'(1);
        unique case (coord_d)
          CoordBottom: begin
            have_rect_d = 1'b1;
            bottom_y_d  = word;
          end
          CoordRight:  right_x_d = word;
          CoordTop:    top_y_d   = word;
          CoordLeft:   left_x_d  = word;
          default: ;
        endcase
      end else begin
        run_sum_d = sum_next;
        if (sum_next >= SumW'(area_q)) begin
          rect_done_d = done_next;
          have_rect_d = 1'b0;
          coord_d     = '0;
          run_sum_d   = '0;
          if (done_next == rect_total_q) begin
            rect_done_d  = '0;
            rect_total_d = '0;
            have_stamp_d = 1'b0;
            have_count_d = 1'b0;
            out_last_d   = 1'b1;
            out_key_d    = !seen_q;
            out_pts_d    = stamp_q;
            seen_d       = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q      <= '0;
      phase_q      <= '0;
      have_stamp_q <= 1'b0;
      have_count_q <= 1'b0;
      have_rect_q  <= 1'b0;
      coord_q      <= '0;
      rect_total_q <= '0;
      rect_done_q  <= '0;
      left_x_q     <= '0;
      top_y_q      <= '0;
      right_x_q    <= '0;
      bottom_y_q   <= '0;
      area_q       <= '0;
      run_sum_q    <= '0;
      seen_q       <= 1'b0;
      stamp_q      <= '0;
      out_valid_q  <= 1'b0;
      out_last_q   <= 1'b0;
      out_key_q    <= 1'b0;
      out_pts_q    <= '0;
    end else begin
      area_q <= (right_x_q - left_x_q) * (bottom_y_q - top_y_q);
      if (accept) begin
        shift_q      <= shift_d;
        phase_q      <= phase_d;
        have_stamp_q <= have_stamp_d;
        have_count_q <= have_count_d;
        have_rect_q  <= have_rect_d;
        coord_q      <= coord_d;
        rect_total_q <= rect_total_d;
        rect_done_q  <= rect_done_d;
        left_x_q     <= left_x_d;
        top_y_q      <= top_y_d;
        right_x_q    <= right_x_d;
        bottom_y_q   <= bottom_y_d;
        run_sum_q    <= run_sum_d;
        seen_q       <= seen_d;
        stamp_q      <= stamp_d;
        out_last_q   <= out_last_d;
        out_key_q    <= out_key_d;
        out_pts_q    <= out_pts_d;
        out_valid_q  <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q  <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_pts_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_key_q;

endmodule

>>> src/cfbp_checker.sv
// Port-level checker for the capture frame boundary parser, with its bind.
// Depends on cfbp_pkg and the top level capture_frame_boundary_parser.
module cfbp_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        s_axis_tvalid,
  input logic                        s_axis_tready,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [cfbp_pkg::WordW-1:0]  m_axis_tdata,
  input logic                        m_axis_tlast,
  input logic                        m_axis_tuser
);
  import cfbp_pkg::*;

  // stalled result is kept
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  a_in_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("accepted byte gave no result");

  a_key_needs_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("key flag without frame end");

  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata == '0)
    else $error("timestamp shown without frame end");

endmodule

bind capture_frame_boundary_parser cfbp_checker u_cfbp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

>>> tb/sv/capture_frame_boundary_parser_tb.sv
// Testbench for capture_frame_boundary_parser: byte-stream stimulus of capture frames,
// a cycle-free parser model predicting one result per byte, and a checking monitor.
// Depends on cfbp_pkg and the capture_frame_boundary_parser RTL.
module capture_frame_boundary_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cfbp_pkg::*;

  typedef struct packed {
    logic        fend;
    logic        key;
    logic [31:0] pts;
  } mark_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tuser;

  logic [7:0]  stream_q[$];
  mark_t       marks_q[$];
  int unsigned fails = 0;
  int unsigned cyc = 0;
  int unsigned marks_seen = 0;
  int unsigned hold_left = 0;
  bit          held = 1'b0;

  // parser model state
  logic [23:0] shift_r = '0;
  logic [1:0]  phase_r = '0;
  logic        got_stamp = 1'b0;
  logic        got_count = 1'b0;
  logic        in_rect = 1'b0;
  logic [2:0]  corner_n = '0;
  logic [31:0] rects_want = '0;
  logic [31:0] rects_seen = '0;
  logic [31:0] x_lo = '0;
  logic [31:0] y_lo = '0;
  logic [31:0] x_hi = '0;
  logic [31:0] y_hi = '0;
  logic [39:0] run_acc = '0;
  logic        first_done = 1'b0;
  logic [31:0] pts_r = '0;

  capture_frame_boundary_parser dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  function automatic logic [39:0] run_len(input logic [7:0] b);
    if (b < RunExpBase) begin
      return 40'(b) + 40'd1;
    end
    return 40'd1 << (b - RunExpBase + RunExpOffset);
  endfunction

  function automatic void parse_byte(input logic [7:0] b);
    mark_t       m;
    logic [31:0] w;
    logic [31:0] area;
    m = '0;
    if (phase_r != PhaseLast) begin
      shift_r = {shift_r[15:0], b};
      phase_r = phase_r + 2'd1;
    end else begin
      w = {b, shift_r[7:0], shift_r[15:8], shift_r[23:16]};
      shift_r = {shift_r[15:0], b};
      phase_r = '0;
      if (!got_stamp) begin
        got_stamp = 1'b1;
        pts_r = w;
        rects_seen = '0;
      end else if (!got_count) begin
        got_count = 1'b1;
        rects_want = w;
      end else if (!in_rect) begin
        corner_n = corner_n + 3'd1;
        case (corner_n)
          CoordBottom: begin
            in_rect = 1'b1;
            y_hi = w;
          end
          CoordRight: x_hi = w;
          CoordTop:   y_lo = w;
          CoordLeft:  x_lo = w;
          default: ;
        endcase
      end else begin
        run_acc = run_acc + run_len(b);
        area = (x_hi - x_lo) * (y_hi - y_lo);
        if (run_acc >= 40'(area)) begin
          rects_seen = rects_seen + 32'd1;
          in_rect = 1'b0;
          corner_n = '0;
          run_acc = '0;
          if (rects_seen == rects_want) begin
            rects_seen = '0;
            rects_want = '0;
            got_stamp = 1'b0;
            got_count = 1'b0;
            m.fend = 1'b1;
            m.key = !first_done;
            m.pts = pts_r;
            first_done = 1'b1;
          end
        end
      end
    end
    marks_q.push_back(m);
  endfunction

  task automatic push_word(input logic [31:0] w);
    for (int i = 0; i < 4; i++) begin
      stream_q.push_back(w[8*i +: 8]);
    end
  endtask

  task automatic push_rect();
    logic [31:0] x1, y1, x2, y2, area;
    logic [39:0] got;
    logic [7:0]  top;
    x1 = $urandom;
    y1 = $urandom;
    case ($urandom_range(9))
      0: begin
        x2 = x1;
        y2 = y1 + $urandom_range(5);
      end
      1: begin
        // negative width wraps to a huge area
        x2 = x1 - $urandom_range(1, 4);
        y2 = y1 + $urandom_range(1, 3);
      end
      default: begin
        x2 = x1 + $urandom_range(1, 8);
        y2 = y1 + $urandom_range(1, 8);
      end
    endcase
    push_word(x1);
    push_word(y1);
    push_word(x2);
    push_word(y2);
    area = (x2 - x1) * (y2 - y1);
    got = '0;
    do begin
      if (area > 32'h0010_0000) begin
        top = 8'($urandom_range(8'hF0, 8'hFF));
      end else if ($urandom_range(7) == 0) begin
        top = 8'($urandom_range(8'hE0, 8'hFF));
      end else if ($urandom_range(3) == 0) begin
        top = 8'($urandom);
      end else begin
        top = 8'($urandom_range(8'h3F));
      end
      got = got + run_len(top);
      push_word({top, 24'($urandom)});
    end while (got < 40'(area));
  endtask

  task automatic push_frame(input logic [31:0] count);
    push_word($urandom);
    push_word(count);
    for (int i = 0; i < int'(count); i++) begin
      push_rect();
    end
  endtask

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("capture_frame_boundary_parser test failed");
    $finish;
  end

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
    end else begin
      cyc <= cyc + 1;
      if (s_axis_tvalid && s_axis_tready) begin
        parse_byte(s_axis_tdata);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (stream_q.size() != 0 &&
            ((cyc >= 1500 && cyc < 2300) || $urandom_range(99) >= 26)) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= stream_q.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic report(input string name, input logic [31:0] want, input logic [31:0] got);
    fails++;
    if (fails <= 60) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, want, got);
    end
  endtask

  // receiver and checker
  always @(posedge clk_i or negedge rst_ni) begin
    mark_t m;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        marks_seen <= marks_seen + 1;
        if (marks_q.size() == 0) begin
          report("unexpected transfer", 32'h0, m_axis_tdata);
        end else begin
          m = marks_q.pop_front();
          if (m_axis_tlast !== m.fend) report("frame_end", 32'(m.fend), 32'(m_axis_tlast));
          if (m_axis_tuser !== m.key) report("key_flag", 32'(m.key), 32'(m_axis_tuser));
          if (m_axis_tdata !== m.pts) report("frame_pts", m.pts, m_axis_tdata);
        end
      end
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else if (!held && marks_seen >= 300) begin
        held <= 1'b1;
        hold_left <= 200;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= (cyc >= 1500 && cyc < 2300) || $urandom_range(99) >= 26;
      end
    end
  end

  initial begin
    // key frame: all-ones stamp, full-width area closed by the largest run
    push_word(32'hFFFF_FFFF);
    push_word(32'd1);
    push_word(32'h0000_0000);
    push_word(32'h0000_0000);
    push_word(32'hFFFF_FFFF);
    push_word(32'h0000_0001);
    push_word(32'hFFFF_FFFF);
    while (stream_q.size() < 980) begin
      push_frame(32'($urandom_range(1, 4)));
    end
    // zero rectangle count never closes; then raw noise
    push_frame(32'd0);
    repeat (24) stream_q.push_back(8'($urandom));

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    do @(negedge clk_i);
    while (stream_q.size() != 0 || s_axis_tvalid || marks_q.size() != 0);
    repeat (4) @(posedge clk_i);
    if (fails == 0) begin
      $display("capture_frame_boundary_parser test passed");
    end else begin
      $display("capture_frame_boundary_parser test failed");
    end
    $finish;
  end

endmodule
